FILE: rtl/assert_macros.svh
// Assertion shorthands; clk and rst_n are taken from the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define LRUFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle
`define LRUFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lrufr_pkg.sv
package lrufr_pkg;

    localparam int NUM_FRAMES_DEF = 64;

    localparam int CMD_W     = 2;
    localparam int FID_W     = 6;
    localparam int FOUND_W   = 1;
    localparam int VIC_W     = 6;
    localparam int CNT_OUT_W = 7;

    localparam int IN_FIELDS_W  = CMD_W + FID_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = FOUND_W + VIC_W + CNT_OUT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int FID_LSB   = CMD_W;
    localparam int VIC_LSB   = FOUND_W;
    localparam int CNT_LSB   = FOUND_W + VIC_W;

    localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd2;

    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
        logic link;
        logic clr_step;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
        logic need_link;
    } ctl_stat_t;

endpackage

FILE: rtl/lrufr_ctrl.sv
module lrufr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output lrufr_pkg::ctl_cmd_t  cmd,
    input  lrufr_pkg::ctl_stat_t stat
);
    import lrufr_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_LINK
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // hold until the result register is free
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = stat.need_link ? ST_LINK : ST_IDLE;
                end
            end
            ST_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

FILE: rtl/lrufr_dp.sv
module lrufr_dp
#(
    parameter int NUM_FRAMES = lrufr_pkg::NUM_FRAMES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [lrufr_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lrufr_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  lrufr_pkg::ctl_cmd_t                cmd,
    output lrufr_pkg::ctl_stat_t               stat
);
    import lrufr_pkg::*;

    localparam int IW  = $clog2(NUM_FRAMES);
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int XW  = ((IW > FID_W) ? IW : FID_W) + 1;
    localparam int VXW = (IW > VIC_W) ? IW : VIC_W;
    localparam int CXW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

    logic                 in_list_mem [NUM_FRAMES];
    logic [IW-1:0]        next_mem    [NUM_FRAMES];
    logic [IW-1:0]        prev_mem    [NUM_FRAMES];

    logic [CMD_W-1:0]     req_cmd_reg;
    logic [IW-1:0]        req_idx_reg;
    logic                 req_ok_reg;
    logic                 il_rd_reg;
    logic [IW-1:0]        nx_rd_reg;
    logic [IW-1:0]        pv_rd_reg;

    logic [IW-1:0]        head_reg, head_next;
    logic [IW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        clr_idx_reg;

    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic [VIC_W-1:0]     out_vic_reg;
    logic [CNT_OUT_W-1:0] out_cnt_reg;

    logic [FID_W-1:0]     fid;
    logic [XW-1:0]        fid_x;
    logic [IW-1:0]        addr_sel;
    logic                 is_victim, is_pin, is_unpin, cnt_nz;
    logic                 do_unlink, do_push, found;
    logic [VXW-1:0]       vic_x;
    logic [CXW-1:0]       cnt_x;

    logic                 il_we, il_wdata;
    logic [IW-1:0]        il_waddr;
    logic                 nx_we;
    logic [IW-1:0]        nx_waddr, nx_wdata;
    logic                 pv_we;
    logic [IW-1:0]        pv_waddr, pv_wdata;

    assign fid   = s_tdata[FID_LSB +: FID_W];
    assign fid_x = XW'(fid);

    assign is_victim = (req_cmd_reg == CMD_VICTIM);
    assign is_pin    = (req_cmd_reg == CMD_PIN);
    assign is_unpin  = (req_cmd_reg == CMD_UNPIN);
    assign cnt_nz    = (count_reg != '0);
    assign addr_sel  = is_victim ? tail_reg : req_idx_reg;

    assign do_unlink = (is_victim && cnt_nz) || (is_pin && req_ok_reg && il_rd_reg);
    assign do_push   = is_unpin && req_ok_reg && !il_rd_reg;
    assign found     = is_victim && cnt_nz;

    assign stat.clr_last  = (clr_idx_reg == IW'(NUM_FRAMES - 1));
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign stat.need_link = do_push && cnt_nz;

    always_comb
    begin
        il_we    = cmd.clr_step || (cmd.commit && (do_unlink || do_push));
        il_waddr = cmd.clr_step ? clr_idx_reg : addr_sel;
        il_wdata = cmd.commit && do_push;

        nx_we    = cmd.commit && ((do_unlink && (addr_sel != head_reg)) || do_push);
        nx_waddr = do_push ? addr_sel : pv_rd_reg;
        nx_wdata = do_push ? (cnt_nz ? head_reg : addr_sel) : nx_rd_reg;

        pv_we    = cmd.link ||
                   (cmd.commit && ((do_unlink && (addr_sel != tail_reg)) || do_push));
        if (cmd.link)
        begin
            pv_waddr = addr_sel;
            pv_wdata = addr_sel;
        end
        else if (do_push)
        begin
            pv_waddr = cnt_nz ? head_reg : addr_sel;
            pv_wdata = addr_sel;
        end
        else
        begin
            pv_waddr = nx_rd_reg;
            pv_wdata = pv_rd_reg;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_unlink)
        begin
            if (addr_sel == head_reg)
            begin
                head_next = nx_rd_reg;
            end
            if (addr_sel == tail_reg)
            begin
                tail_next = pv_rd_reg;
            end
            if (cnt_nz)
            begin
                count_next = count_reg - CW'(1);
            end
        end
        else if (do_push)
        begin
            head_next = addr_sel;
            if (!cnt_nz)
            begin
                tail_next = addr_sel;
            end
            count_next = count_reg + CW'(1);
        end
    end

    assign vic_x = VXW'(addr_sel);
    assign cnt_x = CXW'(count_next);

    always_ff @(posedge clk)
    begin
        if (il_we)
        begin
            in_list_mem[il_waddr] <= il_wdata;
        end
        if (nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (pv_we)
        begin
            prev_mem[pv_waddr] <= pv_wdata;
        end
        if (cmd.lookup)
        begin
            il_rd_reg <= in_list_mem[addr_sel];
            nx_rd_reg <= next_mem[addr_sel];
            pv_rd_reg <= prev_mem[addr_sel];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_cmd_reg <= s_tdata[CMD_W-1:0];
            req_ok_reg  <= (fid_x < XW'(NUM_FRAMES));
            req_idx_reg <= fid_x[IW-1:0];
        end
        if (cmd.commit)
        begin
            out_found_reg <= found;
            out_vic_reg   <= found ? vic_x[VIC_W-1:0] : '0;
            out_cnt_reg   <= cnt_x[CNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step && !stat.clr_last)
            begin
                clr_idx_reg <= clr_idx_reg + IW'(1);
            end
            if (cmd.commit)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                       out_cnt_reg, out_vic_reg, out_found_reg};

endmodule

FILE: rtl/lru_frame_replacer_core.sv
// LRU frame replacer: ordered list of evictable frames, newest at the front.
// Request channel s_*: tdata carries cmd (victim, pin, unpin) and the frame index.
// Result channel m_*: one result per request with found, victim_frame and
// the number of listed frames after the request.
// Each request runs through a lookup cycle, where the membership and link
// memories are read at the addressed frame, and a commit cycle, where the
// list is updated and the result registered. An unpin onto a non-empty list
// needs one further link write on the single write port of the back-link
// memory, so that unpin takes an extra link step after its commit cycle.
// One request is in flight at a time; s_tready rises again as soon as the
// list update is done, even while a result still waits in the output register.
// If the receiver stalls with a result pending, the next request is held in
// its commit cycle until that result is taken.
// After reset the membership memory is cleared one entry per cycle; s_tready
// stays low during that pass.
module lru_frame_replacer_core
#(
    parameter int NUM_FRAMES = lrufr_pkg::NUM_FRAMES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lrufr_pkg::IN_TDATA_W-1:0]   s_tdata,   // cmd, frame
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lrufr_pkg::OUT_TDATA_W-1:0]  m_tdata    // found, victim_frame, listed_count
);
    import lrufr_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    lrufr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lrufr_dp
    #(
        .NUM_FRAMES (NUM_FRAMES)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

FILE: rtl/lrufr_checker.sv
`include "assert_macros.svh"

module lrufr_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [lrufr_pkg::IN_TDATA_W-1:0]   s_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [lrufr_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import lrufr_pkg::*;

    `LRUFR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `LRUFR_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "request taken while busy")
    `LRUFR_ASSERT(a_empty_victim, (m_tvalid && !m_tdata[0]) |-> (m_tdata[VIC_LSB +: VIC_W] == '0), "victim frame set without found")
    `LRUFR_ASSERT(a_result_source, $rose(m_tvalid) |-> !$past(s_tready), "result without a request in flight")

endmodule

bind lru_frame_replacer_core lrufr_checker u_lrufr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
